[hw/rtl/tobb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tobb_pkg
// shared widths, types and state codes of the tick to ohlc bar builder
// ----------------------------------------------------------------------------
package tobb_pkg;

    localparam int PRICE_W = 24;
    localparam int VOL_W   = 24;
    localparam int TIME_W  = 27;
    localparam int BVOL_W  = 32;
    localparam int CVOL_W  = 48;
    localparam int CPV_W   = 64;
    localparam int PV_W    = 48;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_DIVT  = 8'b0000_0100,
        ST_DIVS  = 8'b0000_1000,
        ST_UPD   = 8'b0001_0000,
        ST_VWAP  = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_WAIT  = 8'b1000_0000
    } state_t;

    // control between the sequencer and the serial divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage : tobb_pkg
`default_nettype wire

[hw/rtl/tobb_serial_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tobb_serial_div
// restoring divider, one quotient bit per cycle, 64 by 48 bit
// ----------------------------------------------------------------------------
module tobb_serial_div
    import tobb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [CPV_W-1:0]    dividend,
    input  wire logic [CVOL_W-1:0]   divisor,
    output div_ctl_t                 ctl,
    output logic      [CPV_W-1:0]    quotient,
    output logic      [CVOL_W-1:0]   remainder
);

    logic [CPV_W-1:0]  quo_reg, quo_next;
    logic [CVOL_W:0]   rem_reg, rem_next;
    logic [CVOL_W-1:0] dsr_reg, dsr_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CVOL_W:0]   trial;
    logic [CVOL_W:0]   diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[CVOL_W-1:0], quo_reg[CPV_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 7'(CPV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift one dividend bit into the partial remainder
            if (!diff[CVOL_W]) begin
                rem_next = diff;
                quo_next = {quo_reg[CPV_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[CPV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign ctl.start  = start;
    assign ctl.busy   = busy_reg;
    assign ctl.done   = done_reg;
    assign quotient   = quo_reg;
    assign remainder  = rem_reg[CVOL_W-1:0];

endmodule : tobb_serial_div
`default_nettype wire

[hw/rtl/tick_to_ohlc_bar_builder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tick_to_ohlc_bar_builder_unit
// ohlcv candlestick builder with cumulative session vwap
// ----------------------------------------------------------------------------
// sequence from request to first result: shift-add multiply, two bucket
//   divisions, update, vwap division, emit
// a tick that closes a bar gives its second result after the first
//   leaves, by way of update, vwap division and emit
// one request in flight: a new tick is taken only when idle with no result pending
// reset: async active low, all bar and session state cleared, period 60000
// ----------------------------------------------------------------------------
module tick_to_ohlc_bar_builder_unit
    import tobb_pkg::*;
#(
    parameter int RESET_PERIOD = 60000
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [TIME_W-1:0]   cfg_data,
    // tick requests
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                op,
    input  wire logic [PRICE_W-1:0]  price,
    input  wire logic [VOL_W-1:0]    volume,
    input  wire logic [TIME_W-1:0]   time_ms,
    // bar results
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     last,
    output logic [PRICE_W-1:0]       open_price,
    output logic [PRICE_W-1:0]       high_price,
    output logic [PRICE_W-1:0]       low_price,
    output logic [PRICE_W-1:0]       close_price,
    output logic [BVOL_W-1:0]        bar_volume,
    output logic [TIME_W-1:0]        bar_start_time,
    output logic [TIME_W-1:0]        bar_last_time,
    output logic [PRICE_W-1:0]       vwap,
    output logic [PRICE_W-1:0]       vwap_deviation,
    output logic [PRICE_W-1:0]       session_high,
    output logic [PRICE_W-1:0]       session_low
);

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  period_reg;
    logic               started_reg;
    logic [PRICE_W-1:0] open_reg, high_reg, low_reg, close_reg;
    logic [BVOL_W-1:0]  bvol_reg;
    logic [TIME_W-1:0]  tstart_reg, tlast_reg;
    logic [CVOL_W-1:0]  cvol_reg;
    logic [CPV_W-1:0]   cpv_reg;
    logic [PRICE_W-1:0] shigh_reg, slow_reg;

    // captured request
    logic               op_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic [TIME_W-1:0]  time_reg;

    // shift-add multiplier, one volume bit per cycle
    logic [PV_W-1:0]    pv_reg;
    logic [VOL_W-1:0]   mq_reg;
    logic [PV_W-1:0]    mc_reg;
    logic [4:0]         mcnt_reg;

    logic [CPV_W-1:0]   tq_reg;      // bucket of the tick time
    logic               newbkt_reg;  // tick closes the bar
    logic               second_reg;  // second result of a closing tick pending

    // output register
    logic               ov_reg;

    // divider
    logic               div_start;
    logic [CPV_W-1:0]   div_a;
    logic [CVOL_W-1:0]  div_b;
    div_ctl_t           div_ctl;
    logic [CPV_W-1:0]   div_q;
    logic [CVOL_W-1:0]  div_r;

    logic [TIME_W-1:0]  per_eff;
    logic               new_sess;
    logic [CVOL_W:0]    cvol_sum;
    logic [CPV_W:0]     cpv_sum;
    logic [BVOL_W:0]    bvol_sum;
    logic [PRICE_W-1:0] vq;
    logic [PRICE_W-1:0] dh, dl;

    assign per_eff  = (period_reg == '0) ? TIME_W'(1) : period_reg;
    assign new_sess = op_reg || !started_reg;
    assign cvol_sum = {1'b0, cvol_reg} + (CVOL_W+1)'(vol_reg);
    assign cpv_sum  = {1'b0, cpv_reg} + (CPV_W+1)'(pv_reg);
    assign bvol_sum = {1'b0, bvol_reg} + (BVOL_W+1)'(vol_reg);

    // clamp quotient to the price range
    assign vq = (cvol_reg == '0) ? '0 :
                ((div_q[CPV_W-1:PRICE_W] != '0) ? '1 : div_q[PRICE_W-1:0]);
    assign dh = (high_reg > vq) ? (high_reg - vq) : (vq - high_reg);
    assign dl = (low_reg > vq) ? (low_reg - vq) : (vq - low_reg);

    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_a     = cpv_reg;
        div_b     = cvol_reg;
        case (state_reg)
            ST_MUL:  begin div_a = CPV_W'(time_reg);   div_b = CVOL_W'(per_eff); end
            ST_DIVT: begin div_a = CPV_W'(tstart_reg); div_b = CVOL_W'(per_eff); end
            default: begin div_a = cpv_reg;            div_b = cvol_reg;         end
        endcase
        if (state_reg == ST_MUL && mcnt_reg == 5'd0)
            div_start = 1'b1;
        if (state_reg == ST_DIVT && div_ctl.done)
            div_start = 1'b1;
        // vwap division starts once the update has set the sums
        if (state_reg == ST_VWAP && !div_ctl.busy && !div_ctl.done)
            div_start = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && !in_stall) state_next = ST_MUL;
            ST_MUL:  if (mcnt_reg == 5'd0) state_next = ST_DIVT;
            ST_DIVT: if (div_ctl.done) state_next = ST_DIVS;
            ST_DIVS: if (div_ctl.done) state_next = ST_UPD;
            ST_UPD:  state_next = ST_VWAP;
            ST_VWAP: if (div_ctl.done) state_next = ST_EMIT;
            ST_EMIT: state_next = ST_WAIT;
            ST_WAIT: if (!ov_reg || !out_stall)
                         state_next = second_reg ? ST_UPD : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            period_reg  <= TIME_W'(RESET_PERIOD);
            started_reg <= 1'b0;
            open_reg    <= '0;
            high_reg    <= '0;
            low_reg     <= '0;
            close_reg   <= '0;
            bvol_reg    <= '0;
            tstart_reg  <= '0;
            tlast_reg   <= '0;
            cvol_reg    <= '0;
            cpv_reg     <= '0;
            shigh_reg   <= '0;
            slow_reg    <= '0;
            ov_reg      <= 1'b0;
            second_reg  <= 1'b0;
            newbkt_reg  <= 1'b0;
            mcnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                period_reg <= cfg_data;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    mcnt_reg <= 5'(VOL_W);
                end
                ST_MUL: begin
                    if (mcnt_reg != 5'd0)
                        mcnt_reg <= mcnt_reg - 5'd1;
                end
                ST_DIVS: begin
                    if (div_ctl.done)
                        newbkt_reg <= (tq_reg != div_q);
                end
                ST_UPD: begin
                    if (second_reg) begin
                        // open the new bar after the closed one has left
                        second_reg <= 1'b0;
                        open_reg   <= price_reg;
                        high_reg   <= price_reg;
                        low_reg    <= price_reg;
                        close_reg  <= price_reg;
                        bvol_reg   <= BVOL_W'(vol_reg);
                        tstart_reg <= time_reg;
                        tlast_reg  <= time_reg;
                        cvol_reg   <= cvol_sum[CVOL_W] ? '1 : cvol_sum[CVOL_W-1:0];
                        cpv_reg    <= cpv_sum[CPV_W] ? '1 : cpv_sum[CPV_W-1:0];
                    end else if (new_sess) begin
                        started_reg <= 1'b1;
                        open_reg    <= price_reg;
                        high_reg    <= price_reg;
                        low_reg     <= price_reg;
                        close_reg   <= price_reg;
                        bvol_reg    <= BVOL_W'(vol_reg);
                        tstart_reg  <= time_reg;
                        tlast_reg   <= time_reg;
                        cvol_reg    <= CVOL_W'(vol_reg);
                        cpv_reg     <= CPV_W'(pv_reg);
                        shigh_reg   <= price_reg;
                        slow_reg    <= price_reg;
                    end else begin
                        if (price_reg > shigh_reg) shigh_reg <= price_reg;
                        if (price_reg < slow_reg)  slow_reg  <= price_reg;
                        tlast_reg <= time_reg;
                        if (newbkt_reg) begin
                            // closed bar goes out first, sums unchanged
                            second_reg <= 1'b1;
                        end else begin
                            if (price_reg > high_reg) high_reg <= price_reg;
                            if (price_reg < low_reg)  low_reg  <= price_reg;
                            close_reg <= price_reg;
                            bvol_reg  <= bvol_sum[BVOL_W] ? '1 : bvol_sum[BVOL_W-1:0];
                            cvol_reg  <= cvol_sum[CVOL_W] ? '1 : cvol_sum[CVOL_W-1:0];
                            cpv_reg   <= cpv_sum[CPV_W] ? '1 : cpv_sum[CPV_W-1:0];
                        end
                    end
                end
                ST_EMIT: begin
                    ov_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !in_stall) begin
            op_reg    <= op;
            price_reg <= price;
            vol_reg   <= volume;
            time_reg  <= time_ms;
            pv_reg    <= '0;
            mq_reg    <= volume;
            mc_reg    <= PV_W'(price);
        end
        if (state_reg == ST_MUL && mcnt_reg != 5'd0) begin
            if (mq_reg[0])
                pv_reg <= pv_reg + mc_reg;
            mq_reg <= mq_reg >> 1;
            mc_reg <= mc_reg << 1;
        end
        if (state_reg == ST_DIVT && div_ctl.done)
            tq_reg <= div_q;
        if (state_reg == ST_EMIT) begin
            last           <= !second_reg;
            open_price     <= open_reg;
            high_price     <= high_reg;
            low_price      <= low_reg;
            close_price    <= close_reg;
            bar_volume     <= bvol_reg;
            bar_start_time <= tstart_reg;
            bar_last_time  <= tlast_reg;
            vwap           <= vq;
            vwap_deviation <= (dh > dl) ? dh : dl;
            session_high   <= shigh_reg;
            session_low    <= slow_reg;
        end
    end

    tobb_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .ctl       (div_ctl),
        .quotient  (div_q),
        .remainder (div_r)
    );

    logic unused_rem;
    assign unused_rem = ^div_r ^ div_ctl.start;

endmodule : tick_to_ohlc_bar_builder_unit
`default_nettype wire

[hw/rtl/tobb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tobb_checker
// port level checks of the bar builder
// ----------------------------------------------------------------------------
module tobb_checker
    import tobb_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               cfg_ready,
    input wire logic               last,
    input wire logic [PRICE_W-1:0] high_price,
    input wire logic [PRICE_W-1:0] low_price,
    input wire logic [PRICE_W-1:0] session_high,
    input wire logic [PRICE_W-1:0] session_low
);

    // no new request while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("request taken with result pending");

    // request taken means the unit is busy next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("back to back request");

    // after a closed bar is taken the unit stays busy for the open bar
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> in_stall)
        else $error("closed bar not followed");

    // bar range inside the session range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (high_price <= session_high && low_price >= session_low
                                 && low_price <= high_price))
        else $error("bar outside session range");

    // config is not taken while a result waits
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !out_valid) else $error("config during result");

endmodule : tobb_checker

bind tick_to_ohlc_bar_builder_unit tobb_checker u_tobb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cfg_ready    (cfg_ready),
    .last         (last),
    .high_price   (high_price),
    .low_price    (low_price),
    .session_high (session_high),
    .session_low  (session_low)
);
`default_nettype wire

[dv/tick_to_ohlc_bar_builder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_to_ohlc_bar_builder_unit_test
// self-checking bench: directed tick table, period extremes, then random sessions checked
// against a cycle-free bar model, with random idling on both channels
// ----------------------------------------------------------------------------
module tick_to_ohlc_bar_builder_unit_test;
    import tobb_pkg::*;

    localparam int NUM_RANDOM = 1600;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [CVOL_W-1:0] CVOL_MAX = '1;
    localparam logic [CPV_W-1:0] CPV_MAX = '1;
    localparam logic [BVOL_W-1:0] BVOL_MAX = '1;
    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
    localparam logic OP_CONTINUE = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic               last;
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
        logic [BVOL_W-1:0]  bar_volume;
        logic [TIME_W-1:0]  bar_start_time;
        logic [TIME_W-1:0]  bar_last_time;
        logic [PRICE_W-1:0] vwap;
        logic [PRICE_W-1:0] vwap_deviation;
        logic [PRICE_W-1:0] session_high;
        logic [PRICE_W-1:0] session_low;
    } bar_t;

    typedef struct packed {
        logic               op;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
        logic [TIME_W-1:0]  time_ms;
    } tick_t;

    // directed row: tick plus optional typed-in expectation of the first result
    typedef struct {
        tick_t tk;
        bit    has_ref;
        bar_t  first_bar;
    } tick_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TIME_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = 1'b0;
    logic [PRICE_W-1:0] price = '0;
    logic [VOL_W-1:0] volume = '0;
    logic [TIME_W-1:0] time_ms = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bar_t got;

    tick_to_ohlc_bar_builder_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .price(price), .volume(volume), .time_ms(time_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .last(got.last), .open_price(got.open_price), .high_price(got.high_price),
        .low_price(got.low_price), .close_price(got.close_price),
        .bar_volume(got.bar_volume), .bar_start_time(got.bar_start_time),
        .bar_last_time(got.bar_last_time), .vwap(got.vwap),
        .vwap_deviation(got.vwap_deviation), .session_high(got.session_high),
        .session_low(got.session_low)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // bar model state
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]  m_period;
    logic               m_started;
    logic [PRICE_W-1:0] m_open, m_high, m_low, m_close, m_shigh, m_slow;
    logic [BVOL_W-1:0]  m_vol;
    logic [TIME_W-1:0]  m_tstart, m_tlast;
    logic [CVOL_W-1:0]  m_cvol;
    logic [CPV_W-1:0]   m_cpv;

    bar_t pending_bars[$];
    bit   failed = 1'b0;
    bit   quiet = 1'b0;       // no idling in the final stretch
    longint cycles = 0;

    function automatic logic [PRICE_W-1:0] session_vwap();
        logic [CPV_W-1:0] q;
        if (m_cvol == 0) return '0;
        q = m_cpv / CPV_W'(m_cvol);
        return (q > CPV_W'(PRICE_MAX)) ? PRICE_MAX : q[PRICE_W-1:0];
    endfunction

    function automatic bar_t snapshot_bar(logic lst);
        bar_t b;
        logic [PRICE_W-1:0] v, dh, dl;
        v = session_vwap();
        dh = (m_high > v) ? m_high - v : v - m_high;
        dl = (m_low > v) ? m_low - v : v - m_low;
        b.last = lst;
        b.open_price = m_open;
        b.high_price = m_high;
        b.low_price = m_low;
        b.close_price = m_close;
        b.bar_volume = m_vol;
        b.bar_start_time = m_tstart;
        b.bar_last_time = m_tlast;
        b.vwap = v;
        b.vwap_deviation = (dh > dl) ? dh : dl;
        b.session_high = m_shigh;
        b.session_low = m_slow;
        return b;
    endfunction

    // append one expected bar to the scoreboard queue
    function automatic void queue_bar(bar_t b);
        pending_bars = {pending_bars, b};
    endfunction

    function automatic void open_new_bar(tick_t tk);
        m_open = tk.price;
        m_high = tk.price;
        m_low = tk.price;
        m_close = tk.price;
        m_vol = BVOL_W'(tk.volume);
        m_tstart = tk.time_ms;
        m_tlast = tk.time_ms;
    endfunction

    function automatic void add_to_session(tick_t tk);
        logic [CVOL_W:0] sv;
        logic [CPV_W:0] sp;
        sv = {1'b0, m_cvol} + (CVOL_W+1)'(tk.volume);
        m_cvol = sv[CVOL_W] ? CVOL_MAX : sv[CVOL_W-1:0];
        sp = {1'b0, m_cpv} + (CPV_W+1)'(CPV_W'(tk.price) * CPV_W'(tk.volume));
        m_cpv = sp[CPV_W] ? CPV_MAX : sp[CPV_W-1:0];
    endfunction

    // advance the model by one tick and queue the bars it produces
    function automatic void predict_bars(tick_t tk);
        logic [TIME_W-1:0] per;
        logic [BVOL_W:0] bv;
        per = (m_period == 0) ? TIME_W'(1) : m_period;
        if (tk.op == OP_START || !m_started) begin
            m_started = 1'b1;
            open_new_bar(tk);
            m_cvol = CVOL_W'(tk.volume);
            m_cpv = CPV_W'(tk.price) * CPV_W'(tk.volume);
            m_shigh = tk.price;
            m_slow = tk.price;
            queue_bar(snapshot_bar(1'b1));
            return;
        end
        if (tk.price > m_shigh) m_shigh = tk.price;
        if (tk.price < m_slow) m_slow = tk.price;
        if (tk.time_ms / per != m_tstart / per) begin
            // bar closes: report it with the old sums, then the fresh one
            m_tlast = tk.time_ms;
            queue_bar(snapshot_bar(1'b0));
            open_new_bar(tk);
            add_to_session(tk);
            queue_bar(snapshot_bar(1'b1));
            return;
        end
        if (tk.price > m_high) m_high = tk.price;
        if (tk.price < m_low) m_low = tk.price;
        m_tlast = tk.time_ms;
        m_close = tk.price;
        bv = {1'b0, m_vol} + (BVOL_W+1)'(tk.volume);
        m_vol = bv[BVOL_W] ? BVOL_MAX : bv[BVOL_W-1:0];
        add_to_session(tk);
        queue_bar(snapshot_bar(1'b1));
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls and scoreboard
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        bar_t exp_bar;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_bars.size() == 0) begin
                $display("%0t: unexpected bar result %h", $time, got);
                failed = 1'b1;
            end
            else begin
                exp_bar = pending_bars.pop_front();
                if (exp_bar.last != got.last)
                    $display("%0t: last exp %h got %h", $time, exp_bar.last, got.last);
                if (exp_bar.open_price != got.open_price)
                    $display("%0t: open exp %h got %h", $time,
                             exp_bar.open_price, got.open_price);
                if (exp_bar.high_price != got.high_price)
                    $display("%0t: high exp %h got %h", $time,
                             exp_bar.high_price, got.high_price);
                if (exp_bar.low_price != got.low_price)
                    $display("%0t: low exp %h got %h", $time,
                             exp_bar.low_price, got.low_price);
                if (exp_bar.close_price != got.close_price)
                    $display("%0t: close exp %h got %h", $time,
                             exp_bar.close_price, got.close_price);
                if (exp_bar.bar_volume != got.bar_volume)
                    $display("%0t: bar_volume exp %h got %h", $time,
                             exp_bar.bar_volume, got.bar_volume);
                if (exp_bar.bar_start_time != got.bar_start_time)
                    $display("%0t: start exp %h got %h", $time,
                             exp_bar.bar_start_time, got.bar_start_time);
                if (exp_bar.bar_last_time != got.bar_last_time)
                    $display("%0t: last_time exp %h got %h", $time,
                             exp_bar.bar_last_time, got.bar_last_time);
                if (exp_bar.vwap != got.vwap)
                    $display("%0t: vwap exp %h got %h", $time, exp_bar.vwap, got.vwap);
                if (exp_bar.vwap_deviation != got.vwap_deviation)
                    $display("%0t: deviation exp %h got %h", $time,
                             exp_bar.vwap_deviation, got.vwap_deviation);
                if (exp_bar.session_high != got.session_high)
                    $display("%0t: session_high exp %h got %h", $time,
                             exp_bar.session_high, got.session_high);
                if (exp_bar.session_low != got.session_low)
                    $display("%0t: session_low exp %h got %h", $time,
                             exp_bar.session_low, got.session_low);
                if (exp_bar != got) failed = 1'b1;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic write_period(logic [TIME_W-1:0] value);
        // wait out any bar still in the sequencer before touching the period
        while (pending_bars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        m_period = value;
    endtask

    task automatic send_tick(tick_t tk);
        int n;
        // idle after valid dropped before the next request, at random for longer
        n = 1;
        if (!quiet && $urandom_range(0, 5) == 0)
            n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
        in_valid <= 1'b1;
        op <= tk.op;
        price <= tk.price;
        volume <= tk.volume;
        time_ms <= tk.time_ms;
        predict_bars(tk);
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
    endtask

    function automatic tick_t random_tick(logic [TIME_W-1:0] tbase, int mode);
        tick_t tk;
        tk.op = ($urandom_range(0, 40) == 0) ? OP_START : OP_CONTINUE;
        case (mode)
            0: begin
                tk.price = PRICE_W'($urandom_range(990000, 1010000));
                tk.volume = VOL_W'($urandom_range(0, 5000));
            end
            1: begin
                tk.price = PRICE_W'($urandom());
                tk.volume = VOL_W'($urandom());
            end
            default: begin
                tk.price = ($urandom_range(0, 1)) ? PRICE_MAX : PRICE_W'($urandom());
                tk.volume = '1;
            end
        endcase
        tk.time_ms = (tbase > 86399999) ? TIME_W'(86399999) : tbase;
        return tk;
    endfunction

    tick_row_t dir_rows[$];

    function automatic tick_t mk(logic o, int p, int v, int t);
        tick_t tk;
        tk.op = o;
        tk.price = PRICE_W'(p);
        tk.volume = VOL_W'(v);
        tk.time_ms = TIME_W'(t);
        return tk;
    endfunction

    function automatic void add_row(tick_t tk);
        tick_row_t r;
        r.tk = tk;
        r.has_ref = 1'b0;
        r.first_bar = '0;
        dir_rows = {dir_rows, r};
    endfunction

    // row whose result reads off directly: a session-opening tick
    // with zero volume the vwap is 0, so the deviation is the price itself
    function automatic void add_opening_row(tick_t tk);
        tick_row_t r;
        r.tk = tk;
        r.has_ref = 1'b1;
        r.first_bar = '{1'b1, tk.price, tk.price, tk.price, tk.price,
                        BVOL_W'(tk.volume), tk.time_ms, tk.time_ms,
                        (tk.volume == 0) ? '0 : tk.price,
                        (tk.volume == 0) ? tk.price : '0,
                        tk.price, tk.price};
        dir_rows = {dir_rows, r};
    endfunction

    initial
    begin
        logic [TIME_W-1:0] tnow;
        int mode;
        int burst;
        tick_t tk;
        m_period = TIME_W'(RESET_PERIOD_VAL());
        m_started = 1'b0;
        {m_open, m_high, m_low, m_close, m_shigh, m_slow} = '0;
        {m_vol, m_tstart, m_tlast, m_cvol, m_cpv} = '0;

        // continue tick before any session opens one; zero volume gives zero vwap
        add_opening_row(mk(OP_CONTINUE, 1000, 0, 0));
        add_row(mk(OP_CONTINUE, 2000, 10, 100));
        add_row(mk(OP_CONTINUE, 500, 30, 59999));
        add_row(mk(OP_CONTINUE, 800, 5, 60000));      // new bucket
        add_row(mk(OP_CONTINUE, 'hFFFFFF, 'hFFFFFF, 60001));
        add_row(mk(OP_CONTINUE, 0, 'hFFFFFF, 60002));
        add_opening_row(mk(OP_START, 'hFFFFFF, 'hFFFFFF, 86399999));
        add_row(mk(OP_CONTINUE, 0, 0, 86399999));
        add_opening_row(mk(OP_START, 0, 0, 0));
        add_row(mk(OP_CONTINUE, 0, 1, 'h7FFFFFF));    // all time bits set
        add_opening_row(mk(OP_START, 12345, 7, 1000));
        repeat (6) add_row(mk(OP_CONTINUE, 'hFFFFFF, 'hFFFFFF, 1001));  // bar volume grows past the 24-bit tick volume

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_tick(dir_rows[i].tk);
            if (dir_rows[i].has_ref && pending_bars[$] != dir_rows[i].first_bar) begin
                $display("%0t: row %0d exp %h model %h", $time, i,
                         dir_rows[i].first_bar, pending_bars[$]);
                failed = 1'b1;
            end
        end

        // period extremes: 1 ms and a whole day, then zero treated as one
        write_period(TIME_W'(1));
        for (int i = 0; i < 8; i++) send_tick(mk(OP_CONTINUE, 100 + i, 3, i / 2));
        write_period(TIME_W'(86400000));
        for (int i = 0; i < 4; i++) send_tick(mk(OP_CONTINUE, 50, 2, i * 20000000));
        write_period('0);
        for (int i = 0; i < 4; i++) send_tick(mk(OP_CONTINUE, 70, 1, 5 + i / 2));

        // random sessions: mostly well-formed ascending-time ticks
        tnow = '0;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 400 == 0) begin
                case (n / 400)
                    0: write_period(TIME_W'(1000));
                    1: write_period(TIME_W'($urandom_range(1, 86400000)));
                    2: write_period(TIME_W'(60000));
                    default: write_period('1);
                endcase
            end
            if (n == 800) while (pending_bars.size() != 0) @(posedge clk);
            if (n >= NUM_RANDOM - 150) quiet = 1'b1;
            mode = $urandom_range(0, 19) == 0 ? 2 : ($urandom_range(0, 4) == 0 ? 1 : 0);
            if ($urandom_range(0, 15) == 0) tnow = TIME_W'($urandom());
            else tnow = tnow + TIME_W'($urandom_range(0, 1500));
            tk = random_tick(tnow, mode);
            send_tick(tk);
        end

        while (pending_bars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    function automatic int RESET_PERIOD_VAL();
        return 60000;
    endfunction

endmodule
